[sv/sapld_pkg.sv]
// Shared types, character codes and the nibble alphabet lookup for the
// six-axis puck line decoder. No dependencies.
package sapld_pkg;

  localparam int unsigned NibPos = 24;  // highest line position ever decoded
  localparam int unsigned NumAxes = 6;

  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] CH_KEYS = 8'h6B;  // 'k'
  localparam logic [7:0] CH_MODE = 8'h6D;  // 'm'
  localparam logic [7:0] CH_MOTION = 8'h64;  // 'd'
  localparam logic [7:0] CH_ZRAD = 8'h6E;  // 'n'
  localparam logic [7:0] CH_SENS = 8'h71;  // 'q'
  localparam logic [7:0] CH_ZERO = 8'h7A;  // 'z'
  localparam logic [7:0] CH_VER = 8'h76;  // 'v'
  localparam logic [7:0] CH_ERR = 8'h65;  // 'e'

  typedef enum logic [3:0] {
    KIND_KEYS    = 4'd0,
    KIND_MODE    = 4'd1,
    KIND_MOTION  = 4'd2,
    KIND_ZRAD    = 4'd3,
    KIND_SENS    = 4'd4,
    KIND_ZEROING = 4'd5,
    KIND_VERSION = 4'd6,
    KIND_ERROR   = 4'd7,
    KIND_UNKNOWN = 4'd8
  } kind_e;

  // Stored line as seen by the decoder
  typedef struct packed {
    logic [7:0]               first;
    logic [NibPos:1][3:0]     nib;
    logic [NibPos:1]          bad;    // outside alphabet or past line end
    logic                     empty;
    logic                     ovf;
  } line_t;

  typedef struct packed {
    kind_e                     kind;
    logic [NumAxes-1:0][15:0]  axis;
    logic [11:0]               mask;
    logic [3:0]                n1;
    logic [3:0]                n2;
    logic                      bad;
    logic                      ovf;
  } result_t;

  // Returns {bad, nibble}
  function automatic logic [4:0] nib_decode(logic [7:0] b);
    logic [4:0] r;
    case (b)
      8'h30:   r = {1'b0, 4'd0};
      8'h41:   r = {1'b0, 4'd1};
      8'h42:   r = {1'b0, 4'd2};
      8'h33:   r = {1'b0, 4'd3};
      8'h44:   r = {1'b0, 4'd4};
      8'h35:   r = {1'b0, 4'd5};
      8'h36:   r = {1'b0, 4'd6};
      8'h47:   r = {1'b0, 4'd7};
      8'h48:   r = {1'b0, 4'd8};
      8'h39:   r = {1'b0, 4'd9};
      8'h3A:   r = {1'b0, 4'd10};
      8'h4B:   r = {1'b0, 4'd11};
      8'h3C:   r = {1'b0, 4'd12};
      8'h4D:   r = {1'b0, 4'd13};
      8'h4E:   r = {1'b0, 4'd14};
      8'h3F:   r = {1'b0, 4'd15};
      default: r = {1'b1, 4'd0};
    endcase
    return r;
  endfunction

endpackage

[sv/sapld_line_store.sv]
// Line store: first byte, pre-decoded nibbles of the decodable positions,
// fill count and drop flag. Depends on sapld_pkg.
module sapld_line_store #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [7:0]           wr_byte_i,
  input  logic                 clr_i,
  output sapld_pkg::line_t     line_o
);
  import sapld_pkg::*;

  localparam int unsigned CntW = $clog2(LINE_BYTES + 1);

  logic [CntW-1:0]        fill_q, fill_d;
  logic                   ovf_q, ovf_d;
  logic [7:0]             first_q;
  logic [NibPos:1][3:0]   nib_q;
  logic [NibPos:1]        nbad_q;
  logic [4:0]             dec;
  logic                   room;

  assign dec  = nib_decode(wr_byte_i);
  assign room = fill_q < CntW'(LINE_BYTES);

  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    if (clr_i) begin
      fill_d = '0;
      ovf_d  = 1'b0;
    end else if (wr_en_i) begin
      if (room) begin
        fill_d = fill_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
    end
  end

  // Payload: each slot is written only when the fill count points at it
  always_ff @(posedge clk_i) begin
    if (wr_en_i && !clr_i && room) begin
      if (fill_q == '0) begin
        first_q <= wr_byte_i;
      end
      for (int p = 1; p <= NibPos; p++) begin
        if (fill_q == CntW'(p)) begin
          nib_q[p]  <= dec[3:0];
          nbad_q[p] <= dec[4];
        end
      end
    end
  end

  always_comb begin
    line_o.first = first_q;
    line_o.empty = (fill_q == '0);
    line_o.ovf   = ovf_q;
    for (int p = 1; p <= NibPos; p++) begin
      // past the line end reads as nibble 0, flagged
      if (CntW'(p) < fill_q) begin
        line_o.nib[p] = nib_q[p];
        line_o.bad[p] = nbad_q[p];
      end else begin
        line_o.nib[p] = 4'd0;
        line_o.bad[p] = 1'b1;
      end
    end
  end

endmodule

[sv/sapld_decode.sv]
// Line decoder: turns the stored line into one result by its first
// character. Pure logic. Depends on sapld_pkg.
module sapld_decode (
  input  sapld_pkg::line_t   line_i,
  output sapld_pkg::result_t res_o
);
  import sapld_pkg::*;

  always_comb begin
    res_o      = '0;
    res_o.kind = KIND_UNKNOWN;
    res_o.ovf  = line_i.ovf;
    if (!line_i.empty) begin
      case (line_i.first)
        CH_KEYS: begin
          res_o.kind = KIND_KEYS;
          res_o.mask = {line_i.nib[3], line_i.nib[2], line_i.nib[1]};
          res_o.bad  = |line_i.bad[3:1];
        end
        CH_MODE: begin
          res_o.kind = KIND_MODE;
          res_o.n1   = {1'b0, line_i.nib[1][2:0]};
          res_o.bad  = line_i.bad[1];
        end
        CH_MOTION: begin
          res_o.kind = KIND_MOTION;
          // subtracting the 32768 bias flips the top bit
          for (int a = 0; a < NumAxes; a++) begin
            res_o.axis[a] = {~line_i.nib[4*a+1][3], line_i.nib[4*a+1][2:0],
                             line_i.nib[4*a+2], line_i.nib[4*a+3], line_i.nib[4*a+4]};
          end
          res_o.bad  = |line_i.bad;
        end
        CH_ZRAD: begin
          res_o.kind = KIND_ZRAD;
          res_o.n1   = line_i.nib[1];
          res_o.bad  = line_i.bad[1];
        end
        CH_SENS: begin
          res_o.kind = KIND_SENS;
          res_o.n1   = line_i.nib[1];
          res_o.n2   = line_i.nib[2];
          res_o.bad  = |line_i.bad[2:1];
        end
        CH_ZERO:  res_o.kind = KIND_ZEROING;
        CH_VER:   res_o.kind = KIND_VERSION;
        CH_ERR:   res_o.kind = KIND_ERROR;
        default:  res_o.kind = KIND_UNKNOWN;
      endcase
    end
  end

endmodule

[sv/six_axis_puck_line_decoder_unit.sv]
// Top level of the six-axis puck line decoder: input register, line store,
// decoder and result register. Depends on sapld_pkg, sapld_line_store, sapld_decode.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, rx_byte_i) takes one received byte
//   per transfer. Bytes other than carriage return go into the line store;
//   a full store drops them and flags the line as overflowed.
//   A carriage return decodes the stored line and yields exactly one result
//   on the output channel (out_valid_o/out_ready_i), then empties the store.
//   Other bytes yield no result.
//   A carriage return passes from the input register through the decoder into
//   the result register. Throughput: one byte per cycle except during a stall,
//   set by the single input register feeding the store and the decoder.
//   Stall: while a result waits, ordinary bytes keep flowing into the store;
//   only a second carriage return is held in the input register, and then
//   in_ready_o drops until the waiting result is taken.
//   Reset empties the store, clears the drop flag and both valid flags.
module six_axis_puck_line_decoder_unit #(
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         msg_kind_o,
  output logic signed [15:0] axis_x_o,
  output logic signed [15:0] axis_y_o,
  output logic signed [15:0] axis_z_o,
  output logic signed [15:0] rot_a_o,
  output logic signed [15:0] rot_b_o,
  output logic signed [15:0] rot_c_o,
  output logic [11:0]        button_mask_o,
  output logic [3:0]         first_nibble_o,
  output logic [3:0]         second_nibble_o,
  output logic               bad_char_o,
  output logic               overflowed_o
);
  import sapld_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_is_cr, s1_go;
  logic       out_valid_q;
  result_t    res_q, res_d;
  line_t      line;

  assign s1_is_cr   = (s1_byte_q == CR_BYTE);
  // a carriage return only waits when the result register is still occupied
  assign s1_go      = s1_valid_q && (!s1_is_cr || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  sapld_line_store #(
    .LINE_BYTES(LINE_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s1_go && !s1_is_cr),
    .wr_byte_i (s1_byte_q),
    .clr_i     (s1_go && s1_is_cr),
    .line_o    (line)
  );

  sapld_decode u_decode (
    .line_i (line),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_is_cr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_is_cr) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign msg_kind_o      = res_q.kind;
  assign axis_x_o        = res_q.axis[0];
  assign axis_y_o        = res_q.axis[1];
  assign axis_z_o        = res_q.axis[2];
  assign rot_a_o         = res_q.axis[3];
  assign rot_b_o         = res_q.axis[4];
  assign rot_c_o         = res_q.axis[5];
  assign button_mask_o   = res_q.mask;
  assign first_nibble_o  = res_q.n1;
  assign second_nibble_o = res_q.n2;
  assign bad_char_o      = res_q.bad;
  assign overflowed_o    = res_q.ovf;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_is_cr && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked carriage return");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_is_cr) |=> out_valid_q)
    else $error("carriage return transfer did not produce a result");

  a_store_emptied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_is_cr) |=> (line.empty && !line.ovf))
    else $error("line store not emptied after decode");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(s1_go && s1_is_cr))
    else $error("waiting result overwritten");

endmodule

[test/tb.sv]
// Self-checking testbench for the six-axis puck line decoder: drives serial bytes,
// predicts each decoded line and checks every result. Depends on sapld_pkg and
// six_axis_puck_line_decoder_unit.
module tb;
  import sapld_pkg::*;

  localparam int LINE_CAP = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 570;
  localparam int SEND_IDLE [3] = '{11, 80, 0};
  localparam int RECV_IDLE [3] = '{80, 11, 0};

  localparam logic [7:0] NIB_CHARS [16] = '{
    8'h30, 8'h41, 8'h42, 8'h33, 8'h44, 8'h35, 8'h36, 8'h47,
    8'h48, 8'h39, 8'h3A, 8'h4B, 8'h3C, 8'h4D, 8'h4E, 8'h3F
  };
  localparam logic [7:0] LEAD_CHARS [8] = '{
    CH_KEYS, CH_MODE, CH_MOTION, CH_ZRAD, CH_SENS, CH_ZERO, CH_VER, CH_ERR
  };
  localparam int LEAD_LEN [8] = '{3, 1, 24, 1, 2, 0, 0, 0};

  typedef struct {
    logic [7:0] data;
    bit         hold;  // wait for every pending line result before this byte
  } rx_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [3:0]         msg_kind_o;
  logic signed [15:0] axis_x_o, axis_y_o, axis_z_o;
  logic signed [15:0] rot_a_o, rot_b_o, rot_c_o;
  logic [11:0]        button_mask_o;
  logic [3:0]         first_nibble_o;
  logic [3:0]         second_nibble_o;
  logic               bad_char_o;
  logic               overflowed_o;

  rx_item_t   rx_pending [$];
  result_t    lines_due [$];
  bit         lines_drained = 1'b1;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         mismatches = 0;
  int         cycles = 0;

  // Line store as predicted
  logic [7:0] line_mem [LINE_CAP];
  int         line_len = 0;
  bit         line_drop = 1'b0;

  six_axis_puck_line_decoder_unit #(
    .LINE_BYTES(LINE_CAP)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .msg_kind_o     (msg_kind_o),
    .axis_x_o       (axis_x_o),
    .axis_y_o       (axis_y_o),
    .axis_z_o       (axis_z_o),
    .rot_a_o        (rot_a_o),
    .rot_b_o        (rot_b_o),
    .rot_c_o        (rot_c_o),
    .button_mask_o  (button_mask_o),
    .first_nibble_o (first_nibble_o),
    .second_nibble_o(second_nibble_o),
    .bad_char_o     (bad_char_o),
    .overflowed_o   (overflowed_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Nibble at a line position; absent or invalid characters read as zero and flag
  function automatic logic [3:0] line_nibble(input int pos, inout bit bad);
    if (pos < line_len) begin
      for (int k = 0; k < 16; k++) begin
        if (NIB_CHARS[k] == line_mem[pos]) return 4'(k);
      end
    end
    bad = 1'b1;
    return 4'h0;
  endfunction

  // Store one byte; on carriage return decode the line and return 1
  function automatic bit decode_rx_byte(input logic [7:0] b, output result_t res);
    bit         bad;
    logic [3:0] n_lo, n_mid, n_hi;
    logic [15:0] raw;
    res = '0;
    res.kind = KIND_UNKNOWN;
    bad = 1'b0;
    if (b != CR_BYTE) begin
      if (line_len < LINE_CAP) begin
        line_mem[line_len] = b;
        line_len++;
      end else begin
        line_drop = 1'b1;
      end
      return 1'b0;
    end
    if (line_len > 0) begin
      case (line_mem[0])
        CH_KEYS: begin
          res.kind = KIND_KEYS;
          n_lo = line_nibble(1, bad);
          n_mid = line_nibble(2, bad);
          n_hi = line_nibble(3, bad);
          res.mask = {n_hi, n_mid, n_lo};
        end
        CH_MODE: begin
          res.kind = KIND_MODE;
          n_lo = line_nibble(1, bad);
          res.n1 = n_lo & 4'h7;
        end
        CH_MOTION: begin
          res.kind = KIND_MOTION;
          for (int a = 0; a < NumAxes; a++) begin
            raw = '0;
            for (int j = 1; j <= 4; j++) begin
              n_lo = line_nibble(4 * a + j, bad);
              raw = {raw[11:0], n_lo};
            end
            res.axis[a] = raw - 16'h8000;
          end
        end
        CH_ZRAD: begin
          res.kind = KIND_ZRAD;
          res.n1 = line_nibble(1, bad);
        end
        CH_SENS: begin
          res.kind = KIND_SENS;
          n_lo = line_nibble(1, bad);
          n_mid = line_nibble(2, bad);
          res.n1 = n_lo;
          res.n2 = n_mid;
        end
        CH_ZERO: res.kind = KIND_ZEROING;
        CH_VER:  res.kind = KIND_VERSION;
        CH_ERR:  res.kind = KIND_ERROR;
        default: res.kind = KIND_UNKNOWN;
      endcase
    end
    res.bad = bad;
    res.ovf = line_drop;
    line_len = 0;
    line_drop = 1'b0;
    return 1'b1;
  endfunction

  // Driver: present the next byte once the current one has been transferred
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i <= 8'h00;
    end else if (!in_valid_i || in_ready_o) begin
      if (rx_pending.size() != 0 &&
          !(rx_pending[0].hold && (in_valid_i || !lines_drained)) &&
          $urandom_range(99) >= send_idle) begin
        in_valid_i <= 1'b1;
        rx_byte_i <= rx_pending[0].data;
        void'(rx_pending.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check the result transfer, then predict from the byte transfer
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    bit      wrong;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      lines_drained <= 1'b1;
      line_len = 0;
      line_drop = 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
      if (out_valid_o && out_ready_i) begin
        got.kind = kind_e'(msg_kind_o);
        got.axis = {rot_c_o, rot_b_o, rot_a_o, axis_z_o, axis_y_o, axis_x_o};
        got.mask = button_mask_o;
        got.n1 = first_nibble_o;
        got.n2 = second_nibble_o;
        got.bad = bad_char_o;
        got.ovf = overflowed_o;
        if (lines_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: kind %0d axes %h", got.kind, got.axis);
          mismatches++;
        end else begin
          want = lines_due.pop_front();
          wrong = (got.kind !== want.kind) || (got.axis !== want.axis) ||
                  (got.mask !== want.mask) || (got.n1 !== want.n1) ||
                  (got.n2 !== want.n2) || (got.bad !== want.bad) ||
                  (got.ovf !== want.ovf);
          if (wrong) begin
            if (mismatches < 10) begin
              $display("expected: kind %0d axes %h mask %h nib %h/%h bad %b ovf %b",
                       want.kind, want.axis, want.mask, want.n1, want.n2,
                       want.bad, want.ovf);
              $display("actual:   kind %0d axes %h mask %h nib %h/%h bad %b ovf %b",
                       got.kind, got.axis, got.mask, got.n1, got.n2,
                       got.bad, got.ovf);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (decode_rx_byte(rx_byte_i, want)) lines_due.push_back(want);
      end
      lines_drained <= (lines_due.size() == 0);
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit hold);
    rx_item_t it;
    it.data = b;
    it.hold = hold;
    rx_pending.push_back(it);
  endtask

  task automatic push_line(input string s, input bit hold = 1'b0);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], hold && i == 0);
    push_byte(CR_BYTE, hold && s.len() == 0);
  endtask

  // Mostly well-formed lines with random nibbles; some short, long or noise lines
  task automatic random_line(input bit hold);
    int         sel, roll, len;
    logic [7:0] b;
    sel = $urandom_range(8);
    roll = $urandom_range(99);
    if (roll < 8) begin
      len = $urandom_range(40);
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(255)), hold && i == 0);
      push_byte(CR_BYTE, hold && len == 0);
    end else begin
      if (sel < 8) begin
        b = LEAD_CHARS[sel];
        len = (sel >= 5) ? $urandom_range(3) : LEAD_LEN[sel];
      end else begin
        b = 8'($urandom_range(255));
        if (b == CR_BYTE) b = 8'h00;
        len = $urandom_range(4);
      end
      if (roll < 16) len = $urandom_range(len);
      else if (roll < 22) len = LINE_CAP - 1 + $urandom_range(1, 10);
      push_byte(b, hold);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 4) b = 8'($urandom_range(255));
        else b = NIB_CHARS[$urandom_range(15)];
        if (b == CR_BYTE) b = 8'h00;
        push_byte(b, 1'b0);
      end
      push_byte(CR_BYTE, 1'b0);
    end
  endtask

  initial begin
    int start;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = SEND_IDLE[ph];
      recv_idle = RECV_IDLE[ph];
      if (ph == 0) begin
        push_line("");
        push_line("k???");
        push_line("k0A");
        push_line("mG");
        push_line("mx");
        push_line("n:");
        push_line("q?0");
        push_line("q");
        push_line("z");
        push_line("v");
        push_line("e");
        push_line("x12");
        push_line({"d", "0000", "????", "H000", "G???", "0000", "????"});
      end
      start = rx_pending.size();
      // hold the first line of later phases until the decoder has drained
      random_line(ph != 0);
      while (rx_pending.size() < start + PHASE_BYTES)
        random_line($urandom_range(99) == 0);
      while (rx_pending.size() != 0 || in_valid_i) @(negedge clk_i);
    end
    while (!lines_drained || in_valid_i) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && lines_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
